/* rtl/core/gmc_pkg.sv */
package gmc_pkg;

  // Gate machine states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE_OPEN   = 6'b000001,
    ST_IDLE_CLOSED = 6'b000010,
    ST_OPENING     = 6'b000100,
    ST_CLOSING     = 6'b001000,
    ST_STOPPED     = 6'b010000,
    ST_REVERSING   = 6'b100000
  } gate_st_t;

  // Gate state codes as shown on the result port
  localparam logic [2:0] GS_IDLE_OPEN   = 3'd0;
  localparam logic [2:0] GS_IDLE_CLOSED = 3'd1;
  localparam logic [2:0] GS_OPENING     = 3'd2;
  localparam logic [2:0] GS_CLOSING     = 3'd3;
  localparam logic [2:0] GS_STOPPED     = 3'd4;
  localparam logic [2:0] GS_REVERSING   = 3'd5;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_AUTO   = 2'd2;

  localparam logic DIR_OPEN  = 1'b0;
  localparam logic DIR_CLOSE = 1'b1;

  localparam logic SRC_DRV = 1'b0;
  localparam logic SRC_SEC = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [1:0] REG_ONE_TOUCH = 2'd1;
  localparam logic [1:0] REG_REVERSE   = 2'd2;

  localparam logic [3:0] DEBOUNCE_RST  = 4'd2;
  localparam logic [7:0] ONE_TOUCH_RST = 8'd15;
  localparam logic [7:0] REVERSE_RST   = 8'd25;

  // Button bit positions
  localparam int BTN_DRV_OPEN  = 0;
  localparam int BTN_DRV_CLOSE = 1;
  localparam int BTN_SEC_OPEN  = 2;
  localparam int BTN_SEC_CLOSE = 3;

  // Sensor bit positions
  localparam int SNS_OPEN_LIMIT   = 0;
  localparam int SNS_CLOSED_LIMIT = 1;
  localparam int SNS_OBSTACLE     = 2;

  typedef enum logic [1:0] {
    EV_OPEN_DOWN,
    EV_OPEN_UP,
    EV_CLOSE_DOWN,
    EV_CLOSE_UP
  } gmc_ev_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic [15:0] now;
    logic [3:0]  stable;
    logic [3:0]  prev_stable;
    logic [2:0]  rise;
  } gmc_item_t;

  // Gate machine context
  typedef struct packed {
    gate_st_t    st;
    logic [1:0]  mk;
    logic        src;
    logic        dir;
    logic [15:0] pt;
  } gmc_ctx_t;

  typedef struct packed {
    logic [2:0] gate_state;
    logic [1:0] motion_mode;
    logic       command_source;
    logic       green_lamp;
    logic       red_lamp;
  } gmc_result_t;

  function automatic logic [2:0] gmc_code(gate_st_t st);
    logic [2:0] code;
    unique case (st)
      ST_IDLE_OPEN:   code = GS_IDLE_OPEN;
      ST_IDLE_CLOSED: code = GS_IDLE_CLOSED;
      ST_OPENING:     code = GS_OPENING;
      ST_CLOSING:     code = GS_CLOSING;
      ST_STOPPED:     code = GS_STOPPED;
      ST_REVERSING:   code = GS_REVERSING;
      default:        code = GS_STOPPED;
    endcase
    return code;
  endfunction

  function automatic gmc_ctx_t gmc_stop(gmc_ctx_t ctx);
    gmc_ctx_t r;
    r = ctx;
    r.st = ST_STOPPED;
    r.mk = MODE_NONE;
    return r;
  endfunction

  function automatic gmc_ctx_t gmc_start(gmc_ctx_t ctx, gate_st_t st, logic dir, logic src,
                                         logic [15:0] now);
    gmc_ctx_t r;
    r = ctx;
    r.st  = st;
    r.mk  = MODE_MANUAL;
    r.src = src;
    r.dir = dir;
    r.pt  = now;
    return r;
  endfunction

  function automatic gmc_ctx_t gmc_release(gmc_ctx_t ctx, logic dir, logic src,
                                           logic [15:0] now, logic [7:0] otm);
    gmc_ctx_t    r;
    logic [15:0] held;
    r = ctx;
    held = now - ctx.pt;
    if (ctx.mk == MODE_MANUAL && ctx.dir == dir && ctx.src == src) begin
      if (held < {8'd0, otm}) begin
        r.mk = MODE_AUTO;
      end else begin
        r = gmc_stop(ctx);
      end
    end
    return r;
  endfunction

  function automatic gmc_ctx_t gmc_apply(gmc_ctx_t ctx, gmc_ev_t ev, logic src,
                                         logic [15:0] now, logic [7:0] otm);
    gmc_ctx_t r;
    r = ctx;
    unique case (ev)
      EV_OPEN_DOWN: begin
        if (ctx.st == ST_CLOSING) begin
          // security overrides a driver move, anything else stops
          if (src == SRC_SEC && ctx.src == SRC_DRV) begin
            r = gmc_start(ctx, ST_OPENING, DIR_OPEN, src, now);
          end else begin
            r = gmc_stop(ctx);
          end
        end else if (ctx.st == ST_IDLE_CLOSED || ctx.st == ST_STOPPED) begin
          r = gmc_start(ctx, ST_OPENING, DIR_OPEN, src, now);
        end
      end
      EV_CLOSE_DOWN: begin
        if (ctx.st == ST_OPENING) begin
          if (src == SRC_SEC && ctx.src == SRC_DRV) begin
            r = gmc_start(ctx, ST_CLOSING, DIR_CLOSE, src, now);
          end else begin
            r = gmc_stop(ctx);
          end
        end else if (ctx.st == ST_IDLE_OPEN || ctx.st == ST_STOPPED) begin
          r = gmc_start(ctx, ST_CLOSING, DIR_CLOSE, src, now);
        end
      end
      EV_OPEN_UP: begin
        if (ctx.st == ST_OPENING) begin
          r = gmc_release(ctx, DIR_OPEN, src, now, otm);
        end
      end
      EV_CLOSE_UP: begin
        if (ctx.st == ST_CLOSING) begin
          r = gmc_release(ctx, DIR_CLOSE, src, now, otm);
        end
      end
      default: r = ctx;
    endcase
    return r;
  endfunction

  // One panel's events in fixed order: open press, close press, open release, close release
  function automatic gmc_ctx_t gmc_panel(gmc_ctx_t ctx, logic o, logic c, logic po, logic pc,
                                         logic src, logic [15:0] now, logic [7:0] otm);
    gmc_ctx_t r;
    r = ctx;
    if (o && !po) r = gmc_apply(r, EV_OPEN_DOWN, src, now, otm);
    if (c && !pc) r = gmc_apply(r, EV_CLOSE_DOWN, src, now, otm);
    if (!o && po) r = gmc_apply(r, EV_OPEN_UP, src, now, otm);
    if (!c && pc) r = gmc_apply(r, EV_CLOSE_UP, src, now, otm);
    return r;
  endfunction

endpackage

/* rtl/core/gmc_fifo.sv */
module gmc_fifo import gmc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  // head always sits in slot 0; entries shift down on a read
  logic [WIDTH-1:0] slots [DEPTH];
  logic [CW-1:0]    count;
  logic [CW-1:0]    wr_pos;
  logic             wr_ok;
  logic             rd_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[0];
  assign wr_ok   = wr_en & ~full;
  assign rd_ok   = rd_en & ~empty;
  assign wr_pos  = rd_ok ? (count - CW'(1)) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + CW'(wr_ok) - CW'(rd_ok);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (wr_ok && wr_pos[IW-1:0] == IW'(i)) begin
        slots[i] <= wr_data;
      end else if (rd_ok && i < DEPTH - 1) begin
        slots[i] <= slots[(i + 1) % DEPTH];
      end
    end
  end

endmodule

/* rtl/core/gmc_front.sv */
module gmc_front import gmc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic [3:0] raw_buttons,
  input  logic [2:0] sensors,
  input  logic [3:0] settle_len,
  output gmc_item_t item
);

  logic [15:0] sample_counter;
  logic [3:0]  stable;
  logic [3:0]  stable_next;
  logic [3:0]  counts      [4];
  logic [3:0]  counts_next [4];
  logic [2:0]  prev_sensors;
  logic [3:0]  need;
  logic [3:0]  inc;

  assign need = (settle_len == 4'd0) ? 4'd1 : settle_len;

  // per-button debounce, bits independent
  always_comb begin
    stable_next = stable;
    for (int i = 0; i < 4; i++) begin
      inc = counts[i] + 4'd1;
      counts_next[i] = 4'd0;
      if (raw_buttons[i] != stable[i]) begin
        if (inc >= need) begin
          stable_next[i] = raw_buttons[i];
        end else begin
          counts_next[i] = inc;
        end
      end
    end
  end

  always_comb begin
    item.now         = sample_counter + 16'd1;
    item.stable      = stable_next;
    item.prev_stable = stable;
    item.rise        = sensors & ~prev_sensors;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
      stable         <= '0;
      prev_sensors   <= '0;
      for (int i = 0; i < 4; i++) begin
        counts[i] <= '0;
      end
    end else if (accept) begin
      sample_counter <= item.now;
      stable         <= stable_next;
      prev_sensors   <= sensors;
      for (int i = 0; i < 4; i++) begin
        counts[i] <= counts_next[i];
      end
    end
  end

endmodule

/* rtl/core/gmc_back.sv */
module gmc_back import gmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  gmc_item_t   item,
  input  logic [7:0]  one_touch_max_samples,
  input  logic [7:0]  reverse_samples,
  output gmc_result_t result
);

  gmc_ctx_t   ctx;
  gmc_ctx_t   ctx_next;
  logic [7:0] rr;
  logic [7:0] rr_next;
  logic       was_rev;
  logic       sec_conf;
  logic       drv_conf;
  logic       prev_sec_conf;
  logic       prev_drv_conf;

  assign sec_conf      = item.stable[BTN_SEC_OPEN] & item.stable[BTN_SEC_CLOSE];
  assign drv_conf      = item.stable[BTN_DRV_OPEN] & item.stable[BTN_DRV_CLOSE];
  assign prev_sec_conf = item.prev_stable[BTN_SEC_OPEN] & item.prev_stable[BTN_SEC_CLOSE];
  assign prev_drv_conf = item.prev_stable[BTN_DRV_OPEN] & item.prev_stable[BTN_DRV_CLOSE];

  always_comb begin
    ctx_next = ctx;
    rr_next  = rr;

    // limit edges first
    if (item.rise[SNS_OPEN_LIMIT] &&
        (ctx_next.st == ST_OPENING || ctx_next.st == ST_REVERSING)) begin
      ctx_next.st = ST_IDLE_OPEN;
      ctx_next.mk = MODE_NONE;
      rr_next     = 8'd0;
    end
    if (item.rise[SNS_CLOSED_LIMIT] && ctx_next.st == ST_CLOSING) begin
      ctx_next.st = ST_IDLE_CLOSED;
      ctx_next.mk = MODE_NONE;
    end

    // reversal count-down
    was_rev = (ctx_next.st == ST_REVERSING);
    if (was_rev) begin
      if (rr_next <= 8'd1) begin
        rr_next  = 8'd0;
        ctx_next = gmc_stop(ctx_next);
      end else begin
        rr_next = rr_next - 8'd1;
      end
    end

    // button events, dropped while reversing
    if (!was_rev) begin
      priority if (sec_conf) begin
        if (!prev_sec_conf) ctx_next = gmc_stop(ctx_next);
      end else if (drv_conf) begin
        if (!prev_drv_conf) ctx_next = gmc_stop(ctx_next);
      end else begin
        ctx_next = gmc_panel(ctx_next,
                             item.stable[BTN_SEC_OPEN], item.stable[BTN_SEC_CLOSE],
                             item.prev_stable[BTN_SEC_OPEN], item.prev_stable[BTN_SEC_CLOSE],
                             SRC_SEC, item.now, one_touch_max_samples);
        if (!item.stable[BTN_SEC_OPEN] && !item.stable[BTN_SEC_CLOSE]) begin
          ctx_next = gmc_panel(ctx_next,
                               item.stable[BTN_DRV_OPEN], item.stable[BTN_DRV_CLOSE],
                               item.prev_stable[BTN_DRV_OPEN], item.prev_stable[BTN_DRV_CLOSE],
                               SRC_DRV, item.now, one_touch_max_samples);
        end
      end
    end

    // obstacle edge last
    if (item.rise[SNS_OBSTACLE] && ctx_next.st == ST_CLOSING) begin
      ctx_next.st = ST_REVERSING;
      ctx_next.mk = MODE_MANUAL;
      rr_next     = reverse_samples;
    end

    result.gate_state     = gmc_code(ctx_next.st);
    result.motion_mode    = ctx_next.mk;
    result.command_source = ctx_next.src;
    result.green_lamp     = (ctx_next.st == ST_OPENING) || (ctx_next.st == ST_REVERSING);
    result.red_lamp       = (ctx_next.st == ST_CLOSING);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.st  <= ST_IDLE_CLOSED;
      ctx.mk  <= MODE_NONE;
      ctx.src <= SRC_DRV;
      ctx.dir <= DIR_OPEN;
      ctx.pt  <= '0;
      rr      <= '0;
    end else if (go) begin
      ctx <= ctx_next;
      rr  <= rr_next;
    end
  end

endmodule

/* rtl/core/gate_motion_controller.sv */
// Gate motion controller. Each item pushed is one sample period of the driver and security
// open/close buttons, the two limit switches and the obstacle sensor; each item gives exactly
// one result (gate state, motion mode, command source, green and red lamps) in the result
// queue, in order. One item is taken every clock cycle for as long as results are popped:
// the front stage debounces the buttons and marks sensor edges, a queue of MID_DEPTH items
// separates it from the back stage, which runs the whole sample's event chain through the
// gate state machine combinationally and writes the result queue of OUT_DEPTH items.
// An item is registered in the mid queue and its result in the result queue before the result
// can be popped. Config writes are always ready; index 0 sets the debounce length (4 bits), 1
// the one-touch hold limit, 2 the reversal length, and other indexes are ignored. Write them
// only while the block is quiet. No clearing pass after reset.
module gate_motion_controller import gmc_pkg::*; #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  // sample input
  input  logic       push,
  output logic       full,
  input  logic       driver_open,
  input  logic       driver_close,
  input  logic       security_open,
  input  logic       security_close,
  input  logic       open_limit,
  input  logic       closed_limit,
  input  logic       obstacle,
  // results
  output logic       empty,
  input  logic       pop,
  output logic [2:0] gate_state,
  output logic [1:0] motion_mode,
  output logic       command_source,
  output logic       green_lamp,
  output logic       red_lamp,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [3:0]  settle_len;
  logic [7:0]  one_touch_max_samples;
  logic [7:0]  reverse_samples;

  gmc_item_t   front_item;
  logic [$bits(gmc_item_t)-1:0] mid_rd_data;
  gmc_item_t   back_item;
  logic        mid_full;
  logic        mid_empty;
  logic        out_full;
  logic        back_go;
  gmc_result_t back_result;
  logic [$bits(gmc_result_t)-1:0] out_rd_data;
  gmc_result_t head;

  // config registers, writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_len            <= DEBOUNCE_RST;
      one_touch_max_samples <= ONE_TOUCH_RST;
      reverse_samples       <= REVERSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  settle_len            <= cfg_data[3:0];
        REG_ONE_TOUCH: one_touch_max_samples <= cfg_data;
        REG_REVERSE:   reverse_samples       <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: debounce and edge marking
  gmc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (push & ~mid_full),
    .raw_buttons ({security_close, security_open, driver_close, driver_open}),
    .sensors     ({obstacle, closed_limit, open_limit}),
    .settle_len  (settle_len),
    .item        (front_item)
  );

  assign full = mid_full;

  gmc_fifo #(
    .WIDTH ($bits(gmc_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_item),
    .full    (mid_full),
    .rd_en   (back_go),
    .rd_data (mid_rd_data),
    .empty   (mid_empty)
  );

  assign back_item = gmc_item_t'(mid_rd_data);
  // back advances whenever an item waits and the result queue has room
  assign back_go   = ~mid_empty & ~out_full;

  gmc_back u_back (
    .clk                   (clk),
    .rst                   (rst),
    .go                    (back_go),
    .item                  (back_item),
    .one_touch_max_samples (one_touch_max_samples),
    .reverse_samples       (reverse_samples),
    .result                (back_result)
  );

  gmc_fifo #(
    .WIDTH ($bits(gmc_result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (back_go),
    .wr_data (back_result),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_rd_data),
    .empty   (empty)
  );

  assign head           = gmc_result_t'(out_rd_data);
  assign gate_state     = head.gate_state;
  assign motion_mode    = head.motion_mode;
  assign command_source = head.command_source;
  assign green_lamp     = head.green_lamp;
  assign red_lamp       = head.red_lamp;

endmodule

/* rtl/core/gmc_checker.sv */
module gmc_checker import gmc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [2:0] gate_state,
  input logic [1:0] motion_mode,
  input logic       green_lamp,
  input logic       red_lamp
);

  // nothing to show straight after reset
  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // lamps follow the shown gate state
  a_green: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (green_lamp == (gate_state == GS_OPENING || gate_state == GS_REVERSING)))
    else $error("green lamp disagrees with gate state");

  a_red: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (red_lamp == (gate_state == GS_CLOSING)))
    else $error("red lamp disagrees with gate state");

  // idle or stopped gate has no motion
  a_idle_mode: assert property (@(posedge clk) disable iff (rst)
    (!empty && (gate_state == GS_IDLE_OPEN || gate_state == GS_IDLE_CLOSED ||
                gate_state == GS_STOPPED)) |-> motion_mode == MODE_NONE)
    else $error("motion mode set while gate at rest");

  // an unpopped result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(gate_state) && $stable(motion_mode)))
    else $error("waiting result changed");

endmodule

bind gate_motion_controller gmc_checker u_gmc_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .gate_state  (gate_state),
  .motion_mode (motion_mode),
  .green_lamp  (green_lamp),
  .red_lamp    (red_lamp)
);

/* tb/tb_gate_motion_controller.sv */
`timescale 1ns / 1ps

module tb_gate_motion_controller;
  import gmc_pkg::*;

  // Cycles with no item moving on any channel before the run is abandoned. The longest
  // legal quiet stretch is the receiver hold-off below.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AT = 300;
  localparam int REPORT_MAX = 10;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 160;

  // register index the block must ignore
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // One row of the directed table: a sample (buttons, sensors) or a register write.
  // Where chk is set, want is the typed-in result and stands in for the prediction.
  typedef struct packed {
    row_kind_t   kind;
    logic [3:0]  btn;
    logic [2:0]  sens;
    logic [1:0]  idx;
    logic [7:0]  data;
    logic        chk;
    gmc_result_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       push;
  logic       full;
  logic       driver_open;
  logic       driver_close;
  logic       security_open;
  logic       security_close;
  logic       open_limit;
  logic       closed_limit;
  logic       obstacle;
  logic       empty;
  logic       pop;
  logic [2:0] gate_state;
  logic [1:0] motion_mode;
  logic       command_source;
  logic       green_lamp;
  logic       red_lamp;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  gate_motion_controller dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .driver_open    (driver_open),
    .driver_close   (driver_close),
    .security_open  (security_open),
    .security_close (security_close),
    .open_limit     (open_limit),
    .closed_limit   (closed_limit),
    .obstacle       (obstacle),
    .empty          (empty),
    .pop            (pop),
    .gate_state     (gate_state),
    .motion_mode    (motion_mode),
    .command_source (command_source),
    .green_lamp     (green_lamp),
    .red_lamp       (red_lamp),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Gate model: own copy of the block's state and registers, advanced once per item taken
  // ---------------------------------------------------------------------------------------
  logic [3:0]  cf_debounce;
  logic [7:0]  cf_one_touch;
  logic [7:0]  cf_reverse;

  logic [3:0]  gm_stable;
  logic [3:0]  gm_prev_stable;
  logic [3:0]  gm_count [4];
  logic [1:0]  gm_prev_conf;    // bit 0 security pair, bit 1 driver pair
  logic [2:0]  gm_prev_sens;
  logic [2:0]  gm_state;        // held as the result-port code
  logic [1:0]  gm_mode;
  logic        gm_src;
  logic        gm_dir;
  logic [15:0] gm_press_at;
  logic [15:0] gm_tick;
  logic [7:0]  gm_rev_left;

  gmc_result_t outputs_due [$];   // expected results, oldest first

  int mismatches = 0;
  int results_seen = 0;
  int push_burst = 0;
  int pop_burst = 0;
  int stall_cycles = 0;
  logic [2:0] sens_level = 3'b000;

  function automatic void halt_gate();
    gm_state = GS_STOPPED;
    gm_mode  = MODE_NONE;
  endfunction

  function automatic void begin_move(logic [2:0] st, logic dir, logic src);
    gm_state    = st;
    gm_mode     = MODE_MANUAL;
    gm_src      = src;
    gm_dir      = dir;
    gm_press_at = gm_tick;
  endfunction

  // release of the button that started a manual move: short hold latches auto, long stops
  function automatic void end_hold(logic dir, logic src);
    logic [15:0] held;
    held = gm_tick - gm_press_at;
    if (gm_mode == MODE_MANUAL && gm_dir == dir && gm_src == src) begin
      if (held < {8'd0, cf_one_touch}) gm_mode = MODE_AUTO;
      else halt_gate();
    end
  endfunction

  function automatic void gate_event(gmc_ev_t ev, logic src);
    case (ev)
      EV_OPEN_DOWN: begin
        if (gm_state == GS_CLOSING) begin
          // security may take over a driver move; any other press stops
          if (src == SRC_SEC && gm_src == SRC_DRV) begin_move(GS_OPENING, DIR_OPEN, src);
          else halt_gate();
        end else if (gm_state == GS_IDLE_CLOSED || gm_state == GS_STOPPED) begin
          begin_move(GS_OPENING, DIR_OPEN, src);
        end
      end
      EV_CLOSE_DOWN: begin
        if (gm_state == GS_OPENING) begin
          if (src == SRC_SEC && gm_src == SRC_DRV) begin_move(GS_CLOSING, DIR_CLOSE, src);
          else halt_gate();
        end else if (gm_state == GS_IDLE_OPEN || gm_state == GS_STOPPED) begin
          begin_move(GS_CLOSING, DIR_CLOSE, src);
        end
      end
      EV_OPEN_UP: begin
        if (gm_state == GS_OPENING) end_hold(DIR_OPEN, src);
      end
      EV_CLOSE_UP: begin
        if (gm_state == GS_CLOSING) end_hold(DIR_CLOSE, src);
      end
      default: ;
    endcase
  endfunction

  function automatic void panel_events(int ob, int cb, logic src);
    logic o, c, po, pc;
    o  = gm_stable[ob];
    c  = gm_stable[cb];
    po = gm_prev_stable[ob];
    pc = gm_prev_stable[cb];
    if (o && !po) gate_event(EV_OPEN_DOWN, src);
    if (c && !pc) gate_event(EV_CLOSE_DOWN, src);
    if (!o && po) gate_event(EV_OPEN_UP, src);
    if (!c && pc) gate_event(EV_CLOSE_UP, src);
  endfunction

  function automatic gmc_result_t next_gate_outputs(logic [3:0] raw, logic [2:0] sens);
    gmc_result_t res;
    logic [2:0]  rising;
    logic [3:0]  need;
    logic        sec_both, drv_both, was_rev;
    int          i;
    rising = sens & ~gm_prev_sens;
    need = (cf_debounce == 4'd0) ? 4'd1 : cf_debounce;
    gm_tick = gm_tick + 16'd1;

    for (i = 0; i < 4; i++) begin
      if (raw[i] == gm_stable[i]) begin
        gm_count[i] = 4'd0;
      end else begin
        gm_count[i] = gm_count[i] + 4'd1;
        if (gm_count[i] >= need) begin
          gm_stable[i] = raw[i];
          gm_count[i] = 4'd0;
        end
      end
    end

    // limit edges first
    if (rising[SNS_OPEN_LIMIT] && (gm_state == GS_OPENING || gm_state == GS_REVERSING)) begin
      gm_state    = GS_IDLE_OPEN;
      gm_mode     = MODE_NONE;
      gm_rev_left = 8'd0;
    end
    if (rising[SNS_CLOSED_LIMIT] && gm_state == GS_CLOSING) begin
      gm_state = GS_IDLE_CLOSED;
      gm_mode  = MODE_NONE;
    end

    // reversal countdown; a zero count stops at once
    was_rev = (gm_state == GS_REVERSING);
    if (was_rev) begin
      if (gm_rev_left <= 8'd1) begin
        gm_rev_left = 8'd0;
        halt_gate();
      end else begin
        gm_rev_left = gm_rev_left - 8'd1;
      end
    end

    sec_both = gm_stable[BTN_SEC_OPEN] && gm_stable[BTN_SEC_CLOSE];
    drv_both = gm_stable[BTN_DRV_OPEN] && gm_stable[BTN_DRV_CLOSE];
    // button events are dropped, not queued, on a sample that starts in the reversing state
    if (!was_rev) begin
      if (sec_both) begin
        if (!gm_prev_conf[0]) halt_gate();
      end else if (drv_both) begin
        if (!gm_prev_conf[1]) halt_gate();
      end else begin
        panel_events(BTN_SEC_OPEN, BTN_SEC_CLOSE, SRC_SEC);
        if (!gm_stable[BTN_SEC_OPEN] && !gm_stable[BTN_SEC_CLOSE])
          panel_events(BTN_DRV_OPEN, BTN_DRV_CLOSE, SRC_DRV);
      end
    end
    gm_prev_conf   = {drv_both, sec_both};
    gm_prev_stable = gm_stable;

    if (rising[SNS_OBSTACLE] && gm_state == GS_CLOSING) begin
      gm_state    = GS_REVERSING;
      gm_mode     = MODE_MANUAL;
      gm_rev_left = cf_reverse;
    end
    gm_prev_sens = sens;

    res.gate_state     = gm_state;
    res.motion_mode    = gm_mode;
    res.command_source = gm_src;
    res.green_lamp     = (gm_state == GS_OPENING || gm_state == GS_REVERSING);
    res.red_lamp       = (gm_state == GS_CLOSING);
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------------------
  // Offer one sample after a random gap; push stays high across back-to-back items so it is
  // only ever assigned once per edge. Returns at the edge that took the item.
  task automatic send_sample(input logic [3:0] btn, input logic [2:0] sens, input logic chk,
                             input gmc_result_t want);
    int gap;
    gmc_result_t predicted;
    if (push_burst > 0) begin
      gap = 0;
      push_burst--;
    end else begin
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 31) == 0) push_burst = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    driver_open    <= btn[BTN_DRV_OPEN];
    driver_close   <= btn[BTN_DRV_CLOSE];
    security_open  <= btn[BTN_SEC_OPEN];
    security_close <= btn[BTN_SEC_CLOSE];
    open_limit     <= sens[SNS_OPEN_LIMIT];
    closed_limit   <= sens[SNS_CLOSED_LIMIT];
    obstacle       <= sens[SNS_OBSTACLE];
    do @(posedge clk); while (!(push && !full));
    predicted = next_gate_outputs(btn, sens);
    outputs_due.push_back(chk ? want : predicted);
  endtask

  // Register write, only once the block has drained
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    push <= 1'b0;
    while (outputs_due.size() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_DEBOUNCE:  cf_debounce  = data[3:0];
      REG_ONE_TOUCH: cf_one_touch = data;
      REG_REVERSE:   cf_reverse   = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Hold a button pattern for a run of samples while the sensors drift on their own
  task automatic hold_buttons(input logic [3:0] pat, input int len);
    int k, b;
    for (k = 0; k < len; k++) begin
      for (b = 0; b < 3; b++)
        if ($urandom_range(0, 11) == 0) sens_level[b] = ~sens_level[b];
      send_sample(pat, sens_level, 1'b0, '0);
    end
  endtask

  // Mostly clean press/hold/release episodes long enough to get past the debounce, with
  // mixed patterns (overrides, conflicts) and some raw noise thrown in.
  task automatic random_phase(input int n_items);
    int done, kind, len, rel, need;
    logic [3:0] pat;
    need = (cf_debounce == 4'd0) ? 1 : int'(cf_debounce);
    done = 0;
    while (done < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        pat = 4'b0001 << $urandom_range(0, 3);
        if (kind == 6) pat = pat | (4'b0001 << $urandom_range(0, 3));
        len = need + $urandom_range(0, 24);
        rel = need + $urandom_range(0, 6);
        hold_buttons(pat, len);
        hold_buttons(4'b0000, rel);
        done += len + rel;
      end else if (kind < 9) begin
        len = need + $urandom_range(0, 10);
        hold_buttons(4'($urandom_range(0, 15)), len);
        done += len;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) hold_buttons(4'($urandom_range(0, 15)), 1);
        done += len;
      end
    end
  endtask

  function automatic stim_row_t sample_row(logic [3:0] btn, logic [2:0] sens);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.btn  = btn;
    r.sens = sens;
    return r;
  endfunction

  function automatic stim_row_t checked_row(logic [3:0] btn, logic [2:0] sens,
                                            gmc_result_t want);
    stim_row_t r;
    r = sample_row(btn, sens);
    r.chk  = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t write_row(logic [1:0] idx, logic [7:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, drain and verdict
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t rows [$];
    int ph;
    rst            <= 1'b1;
    push           <= 1'b0;
    driver_open    <= 1'b0;
    driver_close   <= 1'b0;
    security_open  <= 1'b0;
    security_close <= 1'b0;
    open_limit     <= 1'b0;
    closed_limit   <= 1'b0;
    obstacle       <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_DEBOUNCE;
    cfg_data       <= 8'd0;

    // model at reset
    cf_debounce    = DEBOUNCE_RST;
    cf_one_touch   = ONE_TOUCH_RST;
    cf_reverse     = REVERSE_RST;
    gm_stable      = 4'd0;
    gm_prev_stable = 4'd0;
    foreach (gm_count[i]) gm_count[i] = 4'd0;
    gm_prev_conf   = 2'd0;
    gm_prev_sens   = 3'd0;
    gm_state       = GS_IDLE_CLOSED;
    gm_mode        = MODE_NONE;
    gm_src         = SRC_DRV;
    gm_dir         = DIR_OPEN;
    gm_press_at    = 16'd0;
    gm_tick        = 16'd0;
    gm_rev_left    = 8'd0;

    // btn: {sec close, sec open, drv close, drv open}; sens: {obstacle, closed, open}
    // after reset: idle closed, nothing moving
    rows.push_back(checked_row(4'b0000, 3'b000,
                               {GS_IDLE_CLOSED, MODE_NONE, SRC_DRV, 1'b0, 1'b0}));
    // debounce of zero (upper data bits dropped) behaves as one; reversal of zero length
    rows.push_back(write_row(REG_DEBOUNCE, 8'hF0));
    rows.push_back(write_row(REG_REVERSE, 8'd0));
    rows.push_back(checked_row(4'b0001, 3'b000,
                               {GS_OPENING, MODE_MANUAL, SRC_DRV, 1'b1, 1'b0}));
    rows.push_back(sample_row(4'b0000, 3'b000));   // short hold: auto
    rows.push_back(sample_row(4'b0000, 3'b001));   // open limit edge
    rows.push_back(sample_row(4'b1000, 3'b001));   // security close
    rows.push_back(sample_row(4'b1000, 3'b101));   // obstacle while closing
    rows.push_back(sample_row(4'b0000, 3'b100));   // zero-length reversal stops, release dropped
    rows.push_back(sample_row(4'b0011, 3'b000));   // driver pair conflict
    rows.push_back(sample_row(4'b0000, 3'b000));
    rows.push_back(sample_row(4'b0010, 3'b000));   // driver close from stopped
    rows.push_back(sample_row(4'b0110, 3'b000));   // security open overrides driver
    rows.push_back(sample_row(4'b0100, 3'b000));   // driver release masked by security
    rows.push_back(sample_row(4'b0000, 3'b000));   // security short hold: auto
    rows.push_back(checked_row(4'b1100, 3'b000,
                               {GS_STOPPED, MODE_NONE, SRC_SEC, 1'b0, 1'b0}));
    rows.push_back(sample_row(4'b0000, 3'b000));
    // extremes: nothing latches auto, longest reversal, unused index ignored
    rows.push_back(write_row(REG_ONE_TOUCH, 8'd0));
    rows.push_back(write_row(REG_REVERSE, 8'd255));
    rows.push_back(write_row(REG_UNUSED, 8'hFF));
    rows.push_back(sample_row(4'b0001, 3'b000));
    rows.push_back(checked_row(4'b0000, 3'b000,
                               {GS_STOPPED, MODE_NONE, SRC_DRV, 1'b0, 1'b0}));
    rows.push_back(sample_row(4'b0010, 3'b000));
    rows.push_back(sample_row(4'b0010, 3'b100));   // obstacle: long reversal
    rows.push_back(sample_row(4'b0000, 3'b100));   // events ignored while reversing
    rows.push_back(sample_row(4'b0000, 3'b101));   // open limit ends the reversal
    rows.push_back(sample_row(4'b0010, 3'b001));
    rows.push_back(sample_row(4'b0011, 3'b001));   // conflict while closing
    rows.push_back(sample_row(4'b0000, 3'b011));   // closed limit with gate stopped

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_WRITE) write_reg(rows[r].idx, rows[r].data);
      else send_sample(rows[r].btn, rows[r].sens, rows[r].chk, rows[r].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_DEBOUNCE, 8'd1);
          write_reg(REG_ONE_TOUCH, 8'd15);
          write_reg(REG_REVERSE, 8'd3);
        end
        1: begin
          write_reg(REG_DEBOUNCE, 8'd15);
          write_reg(REG_ONE_TOUCH, 8'd255);
          write_reg(REG_REVERSE, 8'd1);
        end
        2: begin
          write_reg(REG_DEBOUNCE, 8'($urandom_range(1, 6)));
          write_reg(REG_ONE_TOUCH, 8'($urandom_range(0, 40)));
          write_reg(REG_REVERSE, 8'($urandom_range(1, 40)));
        end
        3: begin
          write_reg(REG_DEBOUNCE, 8'd2);
          write_reg(REG_ONE_TOUCH, 8'd0);
          write_reg(REG_REVERSE, 8'd255);
        end
        default: begin
          write_reg(REG_DEBOUNCE, 8'($urandom_range(0, 255)));
          write_reg(REG_ONE_TOUCH, 8'($urandom_range(0, 255)));
          write_reg(REG_REVERSE, 8'($urandom_range(0, 255)));
        end
      endcase
      random_phase(PHASE_ITEMS);
    end

    push <= 1'b0;
    while (outputs_due.size() > 0) @(posedge clk);
    // a little longer than the receiver's worst gap, to catch any stray result
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outputs_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Receiver side: random pops, one long hold-off so the block backs up and raises full
  // ---------------------------------------------------------------------------------------
  initial begin : result_side
    int gap;
    bit held_off;
    gmc_result_t got, want;
    held_off = 1'b0;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && results_seen >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (pop_burst > 0) begin
        gap = 0;
        pop_burst--;
      end else begin
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 24) == 0) pop_burst = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (!(pop && !empty));

      got.gate_state     = gate_state;
      got.motion_mode    = motion_mode;
      got.command_source = command_source;
      got.green_lamp     = green_lamp;
      got.red_lamp       = red_lamp;
      if (outputs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result %0d with none outstanding: state %0d mode %0d", results_seen,
                   got.gate_state, got.motion_mode);
      end else begin
        want = outputs_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display({"result %0d: exp state %0d mode %0d src %0d green %0d red %0d, ",
                      "got state %0d mode %0d src %0d green %0d red %0d"}, results_seen,
                     want.gate_state, want.motion_mode, want.command_source,
                     want.green_lamp, want.red_lamp, got.gate_state, got.motion_mode,
                     got.command_source, got.green_lamp, got.red_lamp);
        end
      end
      results_seen++;
    end
  end

  // Watchdog: nothing moving on any channel for too long means the block has hung
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
